[hw/rtl/b64d_pkg.sv]
package b64d_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_DATA  = 2'd0;
  localparam logic [1:0] STATUS_CLEAN = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Input function codes
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Quartet position; PH_PAD2 waits for the second pad
  localparam logic [2:0] PH_0    = 3'd0;
  localparam logic [2:0] PH_1    = 3'd1;
  localparam logic [2:0] PH_2    = 3'd2;
  localparam logic [2:0] PH_3    = 3'd3;
  localparam logic [2:0] PH_PAD2 = 3'd4;

  // Configuration register indexes (byte address = 4 * index)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_DROP_ENABLE = 3'd0;
  localparam logic [2:0] REG_DROP_VALUE  = 3'd1;
  localparam logic [2:0] REG_SYMBOL_62   = 3'd2;
  localparam logic [2:0] REG_SYMBOL_63   = 3'd3;
  localparam logic [2:0] REG_PAD_SYMBOL  = 3'd4;

  // Register reset values
  localparam logic       RST_DROP_ENABLE = 1'b1;
  localparam logic [7:0] RST_DROP_VALUE  = 8'd13;
  localparam logic [7:0] RST_SYMBOL_62   = 8'd43;
  localparam logic [7:0] RST_SYMBOL_63   = 8'd47;
  localparam logic [7:0] RST_PAD_SYMBOL  = 8'd61;

  typedef struct packed {
    logic       drop_enable;
    logic [7:0] drop_value;
    logic [7:0] symbol_62;
    logic [7:0] symbol_63;
    logic [7:0] pad_symbol;
  } cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [5:0] leftover_bits;
    logic       padded_done;
    logic       error_seen;
  } dec_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic [1:0] status;
  } result_t;

endpackage

[hw/rtl/b64d_step.sv]
// Per-character decode: classify, advance the quartet, form the result.
module b64d_step (
  input  b64d_pkg::cfg_t       cfg,
  input  b64d_pkg::dec_state_t st,
  input  logic                 func,
  input  logic [7:0]           char_code,
  output b64d_pkg::dec_state_t st_nxt,
  output b64d_pkg::result_t    res
);

  logic       is_pad;
  logic       is_data;
  logic       is_skip;
  logic [5:0] sym;
  logic [7:0] upper_off;
  logic [7:0] lower_off;
  logic [7:0] digit_off;
  logic       have_byte;
  logic [7:0] data_byte;

  assign upper_off = char_code - 8'd65;
  assign lower_off = char_code - 8'd71;
  assign digit_off = char_code + 8'd4;

  // Class order matters when registers make characters collide
  always_comb begin
    is_pad  = 1'b0;
    is_data = 1'b0;
    is_skip = 1'b0;
    sym     = 6'd0;
    if (char_code == cfg.pad_symbol) begin
      is_pad = 1'b1;
    end else if (char_code == cfg.symbol_63) begin
      is_data = 1'b1;
      sym     = 6'd63;
    end else if (char_code == cfg.symbol_62) begin
      is_data = 1'b1;
      sym     = 6'd62;
    end else if (char_code >= 8'd65 && char_code <= 8'd90) begin
      is_data = 1'b1;
      sym     = upper_off[5:0];
    end else if (char_code >= 8'd97 && char_code <= 8'd122) begin
      is_data = 1'b1;
      sym     = lower_off[5:0];
    end else if (char_code >= 8'd48 && char_code <= 8'd57) begin
      is_data = 1'b1;
      sym     = digit_off[5:0];
    end else if (char_code <= 8'd32 || (char_code >= 8'd127 && char_code <= 8'd160)) begin
      is_skip = 1'b1;
    end
  end

  always_comb begin
    st_nxt       = st;
    res.valid    = 1'b0;
    res.out_byte = 8'd0;
    res.status   = b64d_pkg::STATUS_DATA;
    have_byte    = 1'b0;
    data_byte    = 8'd0;

    if (func == b64d_pkg::FUNC_END) begin
      res.valid = 1'b1;
      res.status = (!st.error_seen && st.phase == b64d_pkg::PH_0) ?
                   b64d_pkg::STATUS_CLEAN : b64d_pkg::STATUS_ERROR;
      st_nxt.phase         = b64d_pkg::PH_0;
      st_nxt.leftover_bits = 6'd0;
      st_nxt.padded_done   = 1'b0;
      st_nxt.error_seen    = 1'b0;
    end else if (st.error_seen || is_skip) begin
      // nothing to do
    end else if (!is_pad && !is_data) begin
      res.valid         = 1'b1;
      res.status        = b64d_pkg::STATUS_ERROR;
      st_nxt.error_seen = 1'b1;
    end else begin
      unique case (st.phase)
        b64d_pkg::PH_0: begin
          if (st.padded_done || is_pad) begin
            res.valid         = 1'b1;
            res.status        = b64d_pkg::STATUS_ERROR;
            st_nxt.error_seen = 1'b1;
          end else begin
            st_nxt.leftover_bits = sym;
            st_nxt.phase         = b64d_pkg::PH_1;
          end
        end
        b64d_pkg::PH_1: begin
          if (is_pad) begin
            res.valid         = 1'b1;
            res.status        = b64d_pkg::STATUS_ERROR;
            st_nxt.error_seen = 1'b1;
          end else begin
            have_byte            = 1'b1;
            data_byte            = {st.leftover_bits, sym[5:4]};
            st_nxt.leftover_bits = {2'b00, sym[3:0]};
            st_nxt.phase         = b64d_pkg::PH_2;
          end
        end
        b64d_pkg::PH_2: begin
          if (is_pad) begin
            st_nxt.padded_done   = 1'b1;
            st_nxt.leftover_bits = 6'd0;
            st_nxt.phase         = b64d_pkg::PH_PAD2;
          end else begin
            have_byte            = 1'b1;
            data_byte            = {st.leftover_bits[3:0], sym[5:2]};
            st_nxt.leftover_bits = {4'b0000, sym[1:0]};
            st_nxt.phase         = b64d_pkg::PH_3;
          end
        end
        b64d_pkg::PH_3: begin
          st_nxt.leftover_bits = 6'd0;
          st_nxt.phase         = b64d_pkg::PH_0;
          if (is_pad) begin
            st_nxt.padded_done = 1'b1;
          end else begin
            have_byte = 1'b1;
            data_byte = {st.leftover_bits[1:0], sym};
          end
        end
        default: begin
          // Second pad required
          if (!is_pad) begin
            res.valid         = 1'b1;
            res.status        = b64d_pkg::STATUS_ERROR;
            st_nxt.error_seen = 1'b1;
          end else begin
            st_nxt.phase = b64d_pkg::PH_0;
          end
        end
      endcase
      if (have_byte && !(cfg.drop_enable && data_byte == cfg.drop_value)) begin
        res.valid    = 1'b1;
        res.out_byte = data_byte;
        res.status   = b64d_pkg::STATUS_DATA;
      end
    end
  end

endmodule

[hw/rtl/base64_stream_decoder.sv]
// Base64 stream decoder.
// Input channel: one beat per character (in_func = 0, in_char_code) or an
// end-of-stream marker (in_func = 1). A beat is taken when in_valid is high
// and in_stall is low.
// Output channel: at most one beat per input beat, carrying a decoded
// byte (out_status = 0), a clean end (1) or a format error (2). Skipped
// control characters, legal pads, first symbols of a quartet and dropped
// bytes give none. Throughput: one character per cycle while in_stall is
// low. The whole decode step sits between the input port and the output
// register, so each result is registered as its beat is accepted.
// Stalling: the output register is backed by one skid entry. in_stall rises
// only while the skid entry is occupied, i.e. after the receiver has held
// off a result and a second one has followed.
// Reset (rst_n low, synchronous): quartet state, error flag and both output
// entries clear; registers return to drop enable on, drop value 13 (CR),
// '+' and '/' for codes 62 and 63, '=' as pad.
// Configuration: APB-style, registers at 4 * index, pready tied high.
// An end-of-stream beat returns the decode state to reset, registers kept.
module base64_stream_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [7:0]                      in_char_code,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic [1:0]                      out_status,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [b64d_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  b64d_pkg::cfg_t       cfg_r;
  b64d_pkg::dec_state_t st_r;
  b64d_pkg::dec_state_t st_nxt;
  b64d_pkg::result_t    res;

  // Output register plus one skid entry (payload carries no reset)
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic [1:0]           out_status_r;
  logic                 skid_valid_r;
  logic [7:0]           skid_byte_r;
  logic [1:0]           skid_status_r;

  logic                 in_fire;
  logic                 out_fire;
  logic                 push;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;
  assign push     = in_fire && res.valid;

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[b64d_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drop_enable <= b64d_pkg::RST_DROP_ENABLE;
      cfg_r.drop_value  <= b64d_pkg::RST_DROP_VALUE;
      cfg_r.symbol_62   <= b64d_pkg::RST_SYMBOL_62;
      cfg_r.symbol_63   <= b64d_pkg::RST_SYMBOL_63;
      cfg_r.pad_symbol  <= b64d_pkg::RST_PAD_SYMBOL;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        b64d_pkg::REG_DROP_ENABLE: cfg_r.drop_enable <= cfg_pwdata[0];
        b64d_pkg::REG_DROP_VALUE:  cfg_r.drop_value  <= cfg_pwdata[7:0];
        b64d_pkg::REG_SYMBOL_62:   cfg_r.symbol_62   <= cfg_pwdata[7:0];
        b64d_pkg::REG_SYMBOL_63:   cfg_r.symbol_63   <= cfg_pwdata[7:0];
        b64d_pkg::REG_PAD_SYMBOL:  cfg_r.pad_symbol  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      b64d_pkg::REG_DROP_ENABLE: cfg_prdata = {31'd0, cfg_r.drop_enable};
      b64d_pkg::REG_DROP_VALUE:  cfg_prdata = {24'd0, cfg_r.drop_value};
      b64d_pkg::REG_SYMBOL_62:   cfg_prdata = {24'd0, cfg_r.symbol_62};
      b64d_pkg::REG_SYMBOL_63:   cfg_prdata = {24'd0, cfg_r.symbol_63};
      b64d_pkg::REG_PAD_SYMBOL:  cfg_prdata = {24'd0, cfg_r.pad_symbol};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // ---- decode step ----
  b64d_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .func      (in_func),
    .char_code (in_char_code),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= b64d_pkg::PH_0;
      st_r.leftover_bits <= 6'd0;
      st_r.padded_done   <= 1'b0;
      st_r.error_seen    <= 1'b0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // ---- output register and skid entry ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input held off; drain skid into the output register
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_byte_r   <= skid_byte_r;
        out_status_r <= skid_status_r;
      end
    end else if (push) begin
      if (!out_valid_r || out_fire) begin
        out_byte_r   <= res.out_byte;
        out_status_r <= res.status;
      end else begin
        skid_byte_r   <= res.out_byte;
        skid_status_r <= res.status;
      end
    end
  end

endmodule

[tb/base64_stream_decoder_test.sv]
`timescale 1ns / 1ps

module base64_stream_decoder_test;
  import b64d_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  // The longest honest gap is the long receiver hold-off plus a few
  // register writes, so this is generous.
  localparam int QUIET_LIMIT = 2000;
  // Length of the forced receiver hold-off, enough to fill the skid entry
  // and push back on the input channel.
  localparam int LONG_HOLD   = 64;
  localparam int MAX_REPORTS = 30;

  // Symbol classes beyond the 64 data codes
  localparam logic [6:0] CLASS_PAD  = 7'd64;
  localparam logic [6:0] CLASS_BAD  = 7'd65;
  localparam logic [6:0] CLASS_SKIP = 7'd66;

  // Ways of spoiling an otherwise well-formed stream
  localparam int FLAW_NONE      = 0;
  localparam int FLAW_TRUNCATE  = 1;
  localparam int FLAW_BAD_CHAR  = 2;
  localparam int FLAW_TRAILING  = 3;
  localparam int FLAW_STRAY_PAD = 4;
  localparam int FLAW_NO_END    = 5;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
    logic       drain;  // hold this beat back until every result has come
  } char_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } decoded_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_func      = 1'b0;
  logic [7:0]  in_char_code = 8'd0;
  logic        out_stall    = 1'b0;
  logic        cfg_psel     = 1'b0;
  logic        cfg_penable  = 1'b0;
  logic        cfg_pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata   = 32'd0;

  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [1:0]  out_status;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Beats waiting to be offered, and results the decoder still owes us
  char_beat_t  pending_q[$];
  decoded_t    decoded_q[$];

  // Private copy of the decoder's registers and quartet state
  cfg_t        dec_cfg = '{drop_enable: RST_DROP_ENABLE, drop_value: RST_DROP_VALUE,
                           symbol_62: RST_SYMBOL_62, symbol_63: RST_SYMBOL_63,
                           pad_symbol: RST_PAD_SYMBOL};
  dec_state_t  dec_st  = '0;

  logic        in_taken = 1'b0;
  logic        drain_next = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          long_hold_num = 0;
  int          long_hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int unsigned beats_queued = 0;
  int unsigned beats_in = 0;
  int unsigned results_out = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 1;

  base64_stream_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------

  // Pad wins over the two configurable symbols, which win over the fixed
  // alphabet, which wins over the skipped control ranges.
  function automatic logic [6:0] symbol_value(input logic [7:0] c);
    if (c == dec_cfg.pad_symbol) return CLASS_PAD;
    if (c == dec_cfg.symbol_63) return 7'd63;
    if (c == dec_cfg.symbol_62) return 7'd62;
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c <= 8'd32 || (c >= 8'd127 && c <= 8'd160)) return CLASS_SKIP;
    return CLASS_BAD;
  endfunction

  // Advances the quartet state by one beat; returns 1 when a result is due.
  function automatic bit decode_beat(input logic func, input logic [7:0] code,
                                     output decoded_t res);
    logic [6:0] v;
    logic [7:0] data_b;
    bit         bad;
    bit         has_data;
    res      = '{data: 8'd0, status: STATUS_DATA};
    bad      = 1'b0;
    has_data = 1'b0;
    data_b   = 8'd0;
    if (func == FUNC_END) begin
      res.status = (!dec_st.error_seen && dec_st.phase == PH_0) ? STATUS_CLEAN : STATUS_ERROR;
      dec_st = '0;
      return 1'b1;
    end
    if (dec_st.error_seen) return 1'b0;
    v = symbol_value(code);
    if (v == CLASS_SKIP) return 1'b0;
    if (v == CLASS_BAD) begin
      bad = 1'b1;
    end else begin
      case (dec_st.phase)
        PH_0: begin
          if (dec_st.padded_done || v == CLASS_PAD) begin
            bad = 1'b1;
          end else begin
            dec_st.leftover_bits = v[5:0];
            dec_st.phase = PH_1;
          end
        end
        PH_1: begin
          if (v == CLASS_PAD) begin
            bad = 1'b1;
          end else begin
            data_b = {dec_st.leftover_bits, v[5:4]};
            dec_st.leftover_bits = {2'b00, v[3:0]};
            dec_st.phase = PH_2;
            has_data = 1'b1;
          end
        end
        PH_2: begin
          if (v == CLASS_PAD) begin
            dec_st.padded_done = 1'b1;
            dec_st.leftover_bits = '0;
            dec_st.phase = PH_PAD2;
          end else begin
            data_b = {dec_st.leftover_bits[3:0], v[5:2]};
            dec_st.leftover_bits = {4'b0000, v[1:0]};
            dec_st.phase = PH_3;
            has_data = 1'b1;
          end
        end
        PH_3: begin
          if (v == CLASS_PAD) begin
            dec_st.padded_done = 1'b1;
          end else begin
            data_b = {dec_st.leftover_bits[1:0], v[5:0]};
            has_data = 1'b1;
          end
          dec_st.leftover_bits = '0;
          dec_st.phase = PH_0;
        end
        default: begin
          // second pad owed
          if (v != CLASS_PAD) bad = 1'b1;
          else dec_st.phase = PH_0;
        end
      endcase
    end
    if (bad) begin
      dec_st.error_seen = 1'b1;
      res.status = STATUS_ERROR;
      return 1'b1;
    end
    if (!has_data) return 1'b0;
    if (dec_cfg.drop_enable && data_b == dec_cfg.drop_value) return 1'b0;
    res.data = data_b;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stream generation
  // ---------------------------------------------------------------------

  task automatic push_beat(input logic func, input logic [7:0] code);
    pending_q.push_back('{func: func, char_code: code, drain: drain_next});
    drain_next = 1'b0;
    beats_queued++;
  endtask

  task automatic push_char(input logic [7:0] code);
    push_beat(FUNC_CHAR, code);
  endtask

  task automatic push_end();
    push_beat(FUNC_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_char(s[i]);
  endtask

  // Character that codes v under the current register settings
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    if (v == 6'd62) return dec_cfg.symbol_62;
    if (v == 6'd63) return dec_cfg.symbol_63;
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 26);
    return 8'("0" + v - 52);
  endfunction

  // Control character that is not currently claimed by a register
  function automatic logic [7:0] skip_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 66));
      if (c > 8'd32) c = c + 8'd94;
    end while (c == dec_cfg.pad_symbol || c == dec_cfg.symbol_62 ||
               c == dec_cfg.symbol_63);
    return c;
  endfunction

  function automatic logic [7:0] bad_char();
    return $urandom_range(0, 1) ? 8'($urandom_range(33, 42)) : 8'($urandom_range(161, 255));
  endfunction

  // Bias towards the drop value so suppression is exercised often
  function automatic logic [7:0] payload_byte();
    return ($urandom_range(0, 7) == 0) ? dec_cfg.drop_value : 8'($urandom_range(0, 255));
  endfunction

  // Encode a random message, optionally spoil it, sprinkle skipped characters
  // through it and, but for FLAW_NO_END, close it with an end-of-stream beat.
  task automatic push_stream(input int flaw);
    logic [7:0]  chars[$];
    logic [23:0] bits;
    int          n_bytes;
    int          k;
    int          pos;
    n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
    for (int i = 0; i < n_bytes; i += 3) begin
      k = (n_bytes - i > 3) ? 3 : n_bytes - i;
      bits[23:16] = payload_byte();
      bits[15:8]  = (k > 1) ? payload_byte() : 8'd0;
      bits[7:0]   = (k > 2) ? payload_byte() : 8'd0;
      chars.push_back(sym_char(bits[23:18]));
      chars.push_back(sym_char(bits[17:12]));
      chars.push_back((k > 1) ? sym_char(bits[11:6]) : dec_cfg.pad_symbol);
      chars.push_back((k > 2) ? sym_char(bits[5:0]) : dec_cfg.pad_symbol);
    end
    case (flaw)
      FLAW_TRUNCATE: begin
        repeat ($urandom_range(1, 3)) if (chars.size() != 0) void'(chars.pop_back());
      end
      FLAW_BAD_CHAR: begin
        pos = $urandom_range(0, chars.size());
        chars.insert(pos, bad_char());
      end
      FLAW_TRAILING: begin
        repeat ($urandom_range(1, 4)) chars.push_back(sym_char(6'($urandom_range(0, 63))));
      end
      FLAW_STRAY_PAD: begin
        pos = $urandom_range(0, chars.size());
        chars.insert(pos, dec_cfg.pad_symbol);
      end
      default: ;
    endcase
    foreach (chars[j]) begin
      if ($urandom_range(0, 9) == 0) push_char(skip_char());
      push_char(chars[j]);
    end
    if (flaw != FLAW_NO_END) push_end();
  endtask

  // Raw bytes, half drawn from the live alphabet
  task automatic push_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) begin
      if ($urandom_range(0, 1)) push_char(8'($urandom_range(0, 255)));
      else push_char(sym_char(6'($urandom_range(0, 63))));
    end
    if ($urandom_range(0, 1)) push_end();
  endtask

  // Mostly clean streams so the quartet state goes deep; one sender pause
  // half way through waits for the decoder to empty completely.
  task automatic run_random(input int target);
    int unsigned first;
    int          mix;
    bit          paused;
    first  = beats_queued;
    paused = 1'b0;
    while (beats_queued - first < target) begin
      if (!paused && beats_queued - first >= target / 2) begin
        drain_next = 1'b1;
        paused = 1'b1;
      end
      mix = $urandom_range(0, 99);
      if (mix < 70) push_stream(FLAW_NONE);
      else if (mix < 85) push_stream($urandom_range(FLAW_TRUNCATE, FLAW_NO_END));
      else push_noise();
    end
  endtask

  // ---------------------------------------------------------------------
  // Register access and phase control
  // ---------------------------------------------------------------------

  // Setup cycle then access cycle; pready is tied high so the write lands
  // on the edge that closes the access cycle.
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_DROP_ENABLE: dec_cfg.drop_enable = value[0];
      REG_DROP_VALUE:  dec_cfg.drop_value  = value;
      REG_SYMBOL_62:   dec_cfg.symbol_62   = value;
      REG_SYMBOL_63:   dec_cfg.symbol_63   = value;
      REG_PAD_SYMBOL:  dec_cfg.pad_symbol  = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic en, input logic [7:0] drop,
                                input logic [7:0] s62, input logic [7:0] s63,
                                input logic [7:0] pad);
    write_reg(REG_DROP_ENABLE, {7'd0, en});
    write_reg(REG_DROP_VALUE, drop);
    write_reg(REG_SYMBOL_62, s62);
    write_reg(REG_SYMBOL_63, s63);
    write_reg(REG_PAD_SYMBOL, pad);
    settings_used++;
  endtask

  // Everything offered, accepted and answered, then a further wait so a
  // beat that owes no result has also cleared the output stage.
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sender: one beat per queue entry, payload held while stalled.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : driver
    if (in_valid && in_taken) void'(pending_q.pop_front());
    if (!in_valid || in_taken) begin
      if (pending_q.size() != 0 && !(pending_q[0].drain && decoded_q.size() != 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid     <= 1'b1;
        in_func      <= pending_q[0].func;
        in_char_code <= pending_q[0].char_code;
      end else begin
        // idle: payload is junk and must be ignored
        in_valid     <= 1'b0;
        in_func      <= 1'($urandom_range(0, 1));
        in_char_code <= 8'($urandom_range(0, 255));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request that is timed
  // here so the sender keeps pushing into a full decoder.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_seen != long_hold_num) begin
      long_hold_seen <= long_hold_num;
      hold_left      <= LONG_HOLD - 1;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks result beats against the oldest expectation, predicts
  // for accepted input beats, and runs the watchdog.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    decoded_t got;
    decoded_t want;
    if (!rst_n) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;

      if (out_valid && !out_stall) begin
        results_out++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed: byte %0d status %0d",
                                    out_byte, out_status));
        end else begin
          want = decoded_q.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (result %0d)",
                                      out_status, want.status, results_out));
          if (out_byte !== want.data)
            report_mismatch($sformatf("byte 0x%02h, expected 0x%02h (result %0d)",
                                      out_byte, want.data, results_out));
        end
      end

      if (in_valid && !in_stall) begin
        beats_in++;
        if (decode_beat(in_func, in_char_code, got)) decoded_q.push_back(got);
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings; slow receiver
    send_idle_pct = 15;
    recv_idle_pct = 75;

    // two zero bytes, skipped controls, then a truncated quartet
    push_text("AAA");
    push_char(8'd160);
    push_char(8'd32);
    push_end();
    // 0xFF and 0xE0, single pad in the last place, clean end
    push_text("/+A=");
    push_end();
    // carriage return suppressed, pad pair, then data after padding
    push_text("DQ==A");
    push_end();
    // pad in first place
    push_text("=");
    push_end();
    // pad in second place
    push_text("T=");
    push_end();
    // data where the second pad belongs
    push_text("TQ=A");
    push_end();
    // out-of-alphabet character
    push_char(8'd255);
    push_end();

    run_random(420);
    long_hold_num++;
    wait_idle();

    // Drop off, alternative alphabet tail; slow sender
    apply_settings(1'b0, 8'd255, "-", "_", ".");
    send_idle_pct = 75;
    recv_idle_pct = 15;
    run_random(500);
    wait_idle();

    // Extremes: control code 0 as a symbol, 255 as a symbol, pad in the
    // skipped range; no idling from here on
    apply_settings(1'b1, 8'd0, 8'd0, 8'd255, 8'd128);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(500);
    wait_idle();

    // Registers that collide with the fixed alphabet, pad at 255
    apply_settings(1'b1, 8'($urandom_range(0, 255)), "A", "0", 8'd255);
    run_random(400);
    long_hold_num++;
    wait_idle();

    repeat (3) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", decoded_q.size()));

    $display("Decoded %0d input beats into %0d result beats under %0d register settings.",
             beats_in, results_out, settings_used);
    $display("Streams were clean, spoilt or noise; receiver held off %0d cycles twice.",
             LONG_HOLD);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_step.sv
hw/rtl/base64_stream_decoder.sv
tb/base64_stream_decoder_test.sv
